// ===== rtl/core/pfba_pkg.sv =====
// pfba_pkg: shared types, sizes, codes and helpers of the page frame bitmap allocator
// used by pfba_ffs, page_frame_bitmap_allocator, pfba_chk, pfba_tb_pkg and testbench; no dependencies
`timescale 1ns / 1ps

package pfba_pkg;

  // store sizes
  localparam int FRAME_COUNT = 2048;
  localparam int SLOT_COUNT  = 1024;

  // bitmap word geometry
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;

  // derived widths
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int FWORDS  = (FRAME_COUNT + WORD_W - 1) / WORD_W;
  localparam int FWIDX_W = (FWORDS > 1) ? $clog2(FWORDS) : 1;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W   = (FRAME_W + 1 > CFG_W) ? FRAME_W + 1 : CFG_W;
  localparam int SLOT_AW = 10;
  localparam int SIDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SWORDS  = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int SWIDX_W = (SWORDS > 1) ? $clog2(SWORDS) : 1;
  localparam int PAGE_SHIFT = 12;
  localparam int VA_W    = 32;
  localparam int PA_W    = 23;

  // address map: heap window is directory 1 (4 MB up to 8 MB)
  localparam logic [VA_W-SLOT_AW-PAGE_SHIFT-1:0] HEAP_DIR = 10'd1;

  // register reset values
  localparam logic [CFG_W-1:0] START_RST = 12'd1024;
  localparam logic [CFG_W-1:0] MEM_RST   = 12'd2048;

  // scan limits
  localparam logic [CMP_W-1:0]   FRAME_LIM  = CMP_W'(FRAME_COUNT);
  localparam logic [SLOT_AW:0]   SLOT_LIM   = (SLOT_AW + 1)'(SLOT_COUNT);
  localparam logic [SWIDX_W-1:0] SLAST_W    = SWIDX_W'(SWORDS - 1);
  localparam logic [WORD_W-1:0]  SLAST_MASK =
    {WORD_W{1'b1}} >> (SWORDS * WORD_W - SLOT_COUNT);

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_FRAMES   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_NO_SLOT  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [FRAME_W-1:0] frame_t;

  // result of the find-first unit
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } ffs_res_t;

  // physical address of a frame, kept to the 23-bit field
  function automatic logic [PA_W-1:0] frame_addr(frame_t f);
    logic [FRAME_W+PA_W+PAGE_SHIFT-1:0] t;
    t = {{PA_W{1'b0}}, f, {PAGE_SHIFT{1'b0}}};
    return t[PA_W-1:0];
  endfunction

  function automatic word_t bit_mask(logic [BIT_W-1:0] b);
    return word_t'(1) << b;
  endfunction

endpackage

// ===== rtl/core/pfba_ram.sv =====
// pfba_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pfba_ffs.sv =====
// pfba_ffs: find-first-set over one bitmap word, six halving steps
// depends on pfba_pkg
`timescale 1ns / 1ps

module pfba_ffs (
  input  pfba_pkg::word_t    vec,
  output pfba_pkg::ffs_res_t res
);
  import pfba_pkg::*;

  word_t            v;
  word_t            lm;
  logic [BIT_W-1:0] idx;

  always_comb begin
    v   = vec;
    idx = '0;
    lm  = '0;
    for (int k = BIT_W - 1; k >= 0; k--) begin
      // lower half empty: move the window up
      lm = ~({WORD_W{1'b1}} << (1 << k));
      if ((v & lm) == '0) begin
        idx[k] = 1'b1;
        v      = v >> (1 << k);
      end
    end
    res.found = |vec;
    res.idx   = idx;
  end

endmodule

// ===== rtl/core/page_frame_bitmap_allocator.sv =====
// page_frame_bitmap_allocator: top level, sequencer around one find-first unit and three rams
// depends on pfba_pkg, pfba_ram, pfba_ffs
`timescale 1ns / 1ps

// Page frame allocator with a kernel heap mapping table. One request word goes in
// (allocate or free), one result word comes out (status, heap virtual address,
// frame physical address). A used-frame bitmap (32 words of 64 bits), a slot
// presence bitmap (16 words of 64 bits) and a slot-to-frame table (1024 entries)
// live in rams; per-word valid flops make both bitmaps read as empty right after
// reset, so there is no clearing pass. An allocate walks the frame bitmap one
// word per cycle from the word holding search_start_frame up to the word holding
// the last present frame, then walks the presence bitmap one word per cycle from
// slot 0; each word goes through the shared 64-bit find-first unit. An empty
// search window is answered without a scan, and a free whose address falls
// outside the heap window is answered without a lookup.
// One request is worked on at a time: in_stall is high from accept until the
// result is loaded into the output register, and the next request is taken the
// cycle after, even while that result still waits on out_stall. Configuration
// writes are applied at once and must only come while no request is in flight.
module page_frame_bitmap_allocator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfba_pkg::CFG_W-1:0]           cfg_wdata,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic [pfba_pkg::VA_W-1:0]            in_virtual_address,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic [pfba_pkg::VA_W-1:0]            out_mapped_address,
  output logic [pfba_pkg::PA_W-1:0]            out_frame_address
);
  import pfba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FSCAN,
    S_SSCAN,
    S_FCHK,
    S_FCLR,
    S_RESP
  } state_t;

  // control state
  state_t                  state_r, state_nxt;
  logic                    in_stall_r, in_stall_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]        start_r, start_nxt;
  logic [CFG_W-1:0]        mem_r, mem_nxt;
  logic [2**FWIDX_W-1:0]   fv_r, fv_nxt;
  logic [2**SWIDX_W-1:0]   pv_r, pv_nxt;

  // datapath
  logic [FWIDX_W-1:0]      fw_r, fw_nxt;
  logic [SWIDX_W-1:0]      sw_r, sw_nxt;
  logic [SLOT_AW-1:0]      slot_r, slot_nxt;
  frame_t                  frame_r, frame_nxt;
  word_t                   fwsave_r, fwsave_nxt;
  status_t                 rs_status_r, rs_status_nxt;
  logic [VA_W-1:0]         rs_va_r, rs_va_nxt;
  logic [PA_W-1:0]         rs_pa_r, rs_pa_nxt;
  status_t                 o_status_r, o_status_nxt;
  logic [VA_W-1:0]         o_va_r, o_va_nxt;
  logic [PA_W-1:0]         o_pa_r, o_pa_nxt;

  // ram ports
  logic                    fb_we, pb_we, sf_we;
  logic [FWIDX_W-1:0]      fb_waddr;
  logic [SWIDX_W-1:0]      pb_waddr;
  logic [SIDX_W-1:0]       sf_waddr;
  word_t                   fb_wdata, pb_wdata, fb_rdata, pb_rdata;
  frame_t                  sf_wdata, sf_rdata;

  // scan helpers
  logic                    acc;
  logic [CMP_W-1:0]        start_c, mem_c, limit_c, lastf_c;
  logic [FWIDX_W-1:0]      first_w, last_w;
  logic [BIT_W-1:0]        lo_b, hi_b;
  word_t                   fword, pword, fcand, scand, ffs_vec;
  ffs_res_t                ffs;
  logic [SLOT_AW-1:0]      va_slot, slot_hit;
  logic                    va_bad;
  frame_t                  frame_hit;

  pfba_ram #(.WIDTH(WORD_W), .DEPTH(FWORDS)) u_frame_bm (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fw_nxt),
    .rdata (fb_rdata)
  );

  pfba_ram #(.WIDTH(WORD_W), .DEPTH(SWORDS)) u_slot_bm (
    .clk   (clk),
    .we    (pb_we),
    .waddr (pb_waddr),
    .wdata (pb_wdata),
    .raddr (sw_nxt),
    .rdata (pb_rdata)
  );

  pfba_ram #(.WIDTH(FRAME_W), .DEPTH(SLOT_COUNT)) u_slot_frame (
    .clk   (clk),
    .we    (sf_we),
    .waddr (sf_waddr),
    .wdata (sf_wdata),
    .raddr (slot_nxt[SIDX_W-1:0]),
    .rdata (sf_rdata)
  );

  pfba_ffs u_ffs (
    .vec (ffs_vec),
    .res (ffs)
  );

  // search window: [start, min(memory_frames, FRAME_COUNT))
  assign start_c = CMP_W'(start_r);
  assign mem_c   = CMP_W'(mem_r);
  assign limit_c = (mem_c < FRAME_LIM) ? mem_c : FRAME_LIM;
  assign lastf_c = limit_c - CMP_W'(1);
  assign first_w = FWIDX_W'(start_c >> BIT_W);
  assign last_w  = FWIDX_W'(lastf_c >> BIT_W);

  // words never written read as empty
  assign fword = fv_r[fw_r] ? fb_rdata : '0;
  assign pword = pv_r[sw_r] ? pb_rdata : '0;

  // free frames of this word that fall in the window
  assign lo_b  = (fw_r == first_w) ? start_c[BIT_W-1:0] : '0;
  assign hi_b  = (fw_r == last_w) ? lastf_c[BIT_W-1:0] : {BIT_W{1'b1}};
  assign fcand = ~fword & ({WORD_W{1'b1}} << lo_b)
                 & ({WORD_W{1'b1}} >> ({BIT_W{1'b1}} - hi_b));
  // free slots, last word trimmed to the table size
  assign scand = ~pword & ((sw_r == SLAST_W) ? SLAST_MASK : {WORD_W{1'b1}});

  assign ffs_vec   = (state_r == S_SSCAN) ? scand : fcand;
  assign frame_hit = FRAME_W'({fw_r, ffs.idx});
  assign slot_hit  = SLOT_AW'({sw_r, ffs.idx});

  // free address decode
  assign va_slot = in_virtual_address[PAGE_SHIFT +: SLOT_AW];
  assign va_bad  = (in_virtual_address[VA_W-1 -: VA_W-SLOT_AW-PAGE_SHIFT] != HEAP_DIR)
                   || ({1'b0, va_slot} >= SLOT_LIM);

  assign acc = in_valid && !in_stall_r;

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    mem_nxt       = mem_r;
    fw_nxt        = fw_r;
    sw_nxt        = sw_r;
    slot_nxt      = slot_r;
    frame_nxt     = frame_r;
    fwsave_nxt    = fwsave_r;
    rs_status_nxt = rs_status_r;
    rs_va_nxt     = rs_va_r;
    rs_pa_nxt     = rs_pa_r;
    o_status_nxt  = o_status_r;
    o_va_nxt      = o_va_r;
    o_pa_nxt      = o_pa_r;
    out_valid_nxt = out_valid_r && out_stall;
    fb_we         = 1'b0;
    fb_waddr      = fw_r;
    fb_wdata      = fword;
    pb_we         = 1'b0;
    pb_waddr      = sw_r;
    pb_wdata      = pword;
    sf_we         = 1'b0;
    sf_waddr      = slot_hit[SIDX_W-1:0];
    sf_wdata      = frame_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEARCH_START: start_nxt = cfg_wdata;
        CFG_MEM_FRAMES:   mem_nxt   = cfg_wdata;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_opcode == OP_ALLOC) begin
            if (start_c >= limit_c) begin
              // empty window
              rs_status_nxt = ST_NO_FRAME;
              rs_va_nxt     = '0;
              rs_pa_nxt     = '0;
              state_nxt     = S_RESP;
            end else begin
              fw_nxt    = first_w;
              state_nxt = S_FSCAN;
            end
          end else begin
            slot_nxt = va_slot;
            sw_nxt   = SWIDX_W'(va_slot >> BIT_W);
            if (va_bad) begin
              rs_status_nxt = ST_BAD_FREE;
              rs_va_nxt     = '0;
              rs_pa_nxt     = '0;
              state_nxt     = S_RESP;
            end else begin
              state_nxt = S_FCHK;
            end
          end
        end
      end

      S_FSCAN: begin
        if (ffs.found) begin
          frame_nxt  = frame_hit;
          fwsave_nxt = fword;
          sw_nxt     = '0;
          state_nxt  = S_SSCAN;
        end else if (fw_r == last_w) begin
          rs_status_nxt = ST_NO_FRAME;
          rs_va_nxt     = '0;
          rs_pa_nxt     = '0;
          state_nxt     = S_RESP;
        end else begin
          fw_nxt = fw_r + FWIDX_W'(1);
        end
      end

      S_SSCAN: begin
        if (ffs.found) begin
          // claim frame and slot together
          slot_nxt      = slot_hit;
          fb_we         = 1'b1;
          fb_wdata      = fwsave_r | bit_mask(frame_r[BIT_W-1:0]);
          pb_we         = 1'b1;
          pb_wdata      = pword | bit_mask(ffs.idx);
          sf_we         = 1'b1;
          rs_status_nxt = ST_OK;
          rs_va_nxt     = {HEAP_DIR, slot_hit, {PAGE_SHIFT{1'b0}}};
          rs_pa_nxt     = frame_addr(frame_r);
          state_nxt     = S_RESP;
        end else if (sw_r == SLAST_W) begin
          rs_status_nxt = ST_NO_SLOT;
          rs_va_nxt     = '0;
          rs_pa_nxt     = '0;
          state_nxt     = S_RESP;
        end else begin
          sw_nxt = sw_r + SWIDX_W'(1);
        end
      end

      S_FCHK: begin
        if (!pword[slot_r[BIT_W-1:0]]) begin
          // slot not mapped
          rs_status_nxt = ST_BAD_FREE;
          rs_va_nxt     = '0;
          rs_pa_nxt     = '0;
          state_nxt     = S_RESP;
        end else begin
          frame_nxt = sf_rdata;
          fw_nxt    = FWIDX_W'(sf_rdata >> BIT_W);
          pb_we     = 1'b1;
          pb_wdata  = pword & ~bit_mask(slot_r[BIT_W-1:0]);
          state_nxt = S_FCLR;
        end
      end

      S_FCLR: begin
        fb_we         = 1'b1;
        fb_wdata      = fword & ~bit_mask(frame_r[BIT_W-1:0]);
        rs_status_nxt = ST_OK;
        rs_va_nxt     = {HEAP_DIR, slot_r, {PAGE_SHIFT{1'b0}}};
        rs_pa_nxt     = frame_addr(frame_r);
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        // load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          o_status_nxt  = rs_status_r;
          o_va_nxt      = rs_va_r;
          o_pa_nxt      = rs_pa_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    fv_nxt = fv_r;
    if (fb_we) begin
      fv_nxt[fb_waddr] = 1'b1;
    end
    pv_nxt = pv_r;
    if (pb_we) begin
      pv_nxt[pb_waddr] = 1'b1;
    end

    in_stall_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    fw_r        <= fw_nxt;
    sw_r        <= sw_nxt;
    slot_r      <= slot_nxt;
    frame_r     <= frame_nxt;
    fwsave_r    <= fwsave_nxt;
    rs_status_r <= rs_status_nxt;
    rs_va_r     <= rs_va_nxt;
    rs_pa_r     <= rs_pa_nxt;
    o_status_r  <= o_status_nxt;
    o_va_r      <= o_va_nxt;
    o_pa_r      <= o_pa_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
      start_r     <= START_RST;
      mem_r       <= MEM_RST;
      fv_r        <= '0;
      pv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      mem_r       <= mem_nxt;
      fv_r        <= fv_nxt;
      pv_r        <= pv_nxt;
    end
  end

  assign in_stall           = in_stall_r;
  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_mapped_address = o_va_r;
  assign out_frame_address  = o_pa_r;

endmodule

// ===== rtl/core/pfba_chk.sv =====
// pfba_chk: port-level assertions for page_frame_bitmap_allocator, bound to the top level
// depends on pfba_pkg
`timescale 1ns / 1ps

module pfba_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [1:0]                     out_status,
  input logic [pfba_pkg::VA_W-1:0]      out_mapped_address,
  input logic [pfba_pkg::PA_W-1:0]      out_frame_address
);
  import pfba_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_mapped_address) && $stable(out_frame_address))
    else $error("result word changed under stall");

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // error results carry no addresses
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_mapped_address == '0) && (out_frame_address == '0))
    else $error("error result with nonzero address");

  // good results sit in the heap window and are page aligned
  a_ok_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |->
      (out_mapped_address[VA_W-1:SLOT_AW+PAGE_SHIFT] == HEAP_DIR)
      && (out_mapped_address[PAGE_SHIFT-1:0] == '0)
      && (out_frame_address[PAGE_SHIFT-1:0] == '0))
    else $error("good result outside heap window or misaligned");

endmodule

bind page_frame_bitmap_allocator pfba_chk u_pfba_chk (.*);

// ===== verif/pfba_tb_pkg.sv =====
// pfba_tb_pkg: allocation predictor and result scoreboard for the page frame allocator bench
// depends on pfba_pkg for sizes, opcodes and status codes
`timescale 1ns / 1ps

package pfba_tb_pkg;

  import pfba_pkg::*;

  localparam int DIR_W = VA_W - SLOT_AW - PAGE_SHIFT;

  typedef struct {
    status_t           status;
    logic [VA_W-1:0]   mapped;
    logic [PA_W-1:0]   frame_pa;
  } alloc_result_t;

  class frame_map_scoreboard;
    // mirror of the allocator state
    bit [FRAME_COUNT-1:0] frame_busy;
    bit [SLOT_COUNT-1:0]  slot_busy;
    logic [FRAME_W-1:0]   slot_frame [SLOT_COUNT];
    logic [CFG_W-1:0]     search_start;
    logic [CFG_W-1:0]     mem_frames;

    alloc_result_t results_due [$];
    int            results_seen;
    int            mismatches;

    function new();
      frame_busy   = '0;
      slot_busy    = '0;
      foreach (slot_frame[i]) slot_frame[i] = '0;
      search_start = START_RST;
      mem_frames   = MEM_RST;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function void report_mismatch(string msg);
      if (mismatches < 50) $display("ERROR result %0d: %s", results_seen, msg);
      mismatches++;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_SEARCH_START) search_start = data;
      else if (idx == CFG_MEM_FRAMES) mem_frames = data;
    endfunction

    function int outstanding();
      return results_due.size();
    endfunction

    function int slots_in_use();
      return $countones(slot_busy);
    endfunction

    // random present slot, or -1 when the table is empty
    function int pick_present_slot();
      int base;
      int s;
      if (slot_busy == '0) return -1;
      base = $urandom_range(SLOT_COUNT - 1, 0);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        s = (base + i) % SLOT_COUNT;
        if (slot_busy[s]) return s;
      end
      return -1;
    endfunction

    // work out the result word of one accepted request and update the mirror
    function void note_request(logic opcode, logic [VA_W-1:0] va);
      alloc_result_t      r;
      int                 lim;
      int                 frame;
      int                 slot;
      logic [SLOT_AW-1:0] vslot;
      r.status   = ST_OK;
      r.mapped   = '0;
      r.frame_pa = '0;
      if (opcode == OP_ALLOC) begin
        lim   = (int'(mem_frames) < FRAME_COUNT) ? int'(mem_frames) : FRAME_COUNT;
        frame = -1;
        for (int f = int'(search_start); f < lim; f++) begin
          if (!frame_busy[f]) begin
            frame = f;
            break;
          end
        end
        slot = -1;
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (!slot_busy[s]) begin
            slot = s;
            break;
          end
        end
        if (frame < 0) begin
          r.status = ST_NO_FRAME;
        end else if (slot < 0) begin
          r.status = ST_NO_SLOT;
        end else begin
          frame_busy[frame] = 1'b1;
          slot_busy[slot]   = 1'b1;
          slot_frame[slot]  = FRAME_W'(frame);
          r.mapped   = {HEAP_DIR, SLOT_AW'(slot), {PAGE_SHIFT{1'b0}}};
          r.frame_pa = PA_W'(frame * 4096);
        end
      end else begin
        vslot = va[PAGE_SHIFT +: SLOT_AW];
        if (va[VA_W-1 -: DIR_W] != HEAP_DIR || int'(vslot) >= SLOT_COUNT ||
            !slot_busy[vslot]) begin
          r.status = ST_BAD_FREE;
        end else begin
          frame = int'(slot_frame[vslot]);
          frame_busy[frame] = 1'b0;
          slot_busy[vslot]  = 1'b0;
          slot_frame[vslot] = '0;
          r.mapped   = {va[VA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
          r.frame_pa = PA_W'(frame * 4096);
        end
      end
      results_due.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [VA_W-1:0] mapped,
                               logic [PA_W-1:0] frame_pa);
      alloc_result_t want;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result word with nothing outstanding, status %0d", status));
        results_seen++;
        return;
      end
      want = results_due.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (mapped !== want.mapped)
        report_mismatch($sformatf("mapped_address %h, want %h", mapped, want.mapped));
      if (frame_pa !== want.frame_pa)
        report_mismatch($sformatf("frame_address %h, want %h", frame_pa, want.frame_pa));
      results_seen++;
    endfunction

    function void check_drained();
      if (results_due.size() != 0)
        report_mismatch($sformatf("%0d result words never arrived", results_due.size()));
    endfunction
  endclass

endpackage

// ===== verif/testbench.sv =====
// testbench: self-checking bench for page_frame_bitmap_allocator
// depends on pfba_pkg and pfba_tb_pkg; drives requests, random stalls and config writes
`timescale 1ns / 1ps

module testbench;

  import pfba_pkg::*;
  import pfba_tb_pkg::*;

  localparam int LIMIT_NS    = 20_000_000; // hard stop, far beyond the slowest legal run
  localparam int HOLD_CYCLES = 400;        // long receiver hold-off
  localparam int TAIL_CYCLES = 80;         // idle tail before the final drain check

  // receiver stall behavior, picked anew at random by the receiver
  typedef enum logic [1:0] {RX_READY, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  logic                  in_valid;
  logic                  in_stall;
  logic                  in_opcode;
  logic [VA_W-1:0]       in_virtual_address;

  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_status;
  logic [VA_W-1:0]       out_mapped_address;
  logic [PA_W-1:0]       out_frame_address;

  frame_map_scoreboard sb;

  // long hold-off handshake between the main sequence and the receiver
  int hold_requests = 0;
  int holds_done    = 0;

  page_frame_bitmap_allocator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_virtual_address (in_virtual_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_mapped_address (out_mapped_address),
    .out_frame_address  (out_frame_address)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sample both channels at the rising edge; request words feed the predictor,
  // result words are checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request(in_opcode, in_virtual_address);
      if (out_valid && !out_stall)
        sb.check_result(out_status, out_mapped_address, out_frame_address);
    end
  end

  // receiver: stalls on a pattern of its own, plus a long hold-off on request
  initial begin : receiver
    rx_mode_t   mode;
    int         mode_left;
    logic [7:0] pattern;
    out_stall = 1'b0;
    mode      = RX_READY;
    mode_left = 0;
    pattern   = 8'h0F;
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        // hold off long enough that the block fills up and stalls its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(3, 0));
          mode_left = $urandom_range(150, 20);
          pattern   = $urandom;
        end
        mode_left--;
        case (mode)
          RX_READY:  out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(99, 0) < 25);
          RX_HEAVY:  out_stall <= ($urandom_range(99, 0) < 75);
          default: begin
            out_stall <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  // safety net against a hung handshake
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // present one request word and hold it until taken; returns at the falling
  // edge after the accept, with valid still high
  task automatic send_word(logic opcode, logic [VA_W-1:0] va);
    in_valid           <= 1'b1;
    in_opcode          <= opcode;
    in_virtual_address <= va;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // lower valid and wait out the given gap
  task automatic drop_valid(int gap);
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  // wait until every predicted result word has come back
  task automatic wait_idle();
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // free address: mostly a live heap page, else near misses and noise
  function automatic logic [VA_W-1:0] free_address();
    int pick;
    int slot;
    pick = $urandom_range(99, 0);
    slot = sb.pick_present_slot();
    if (pick < 70 && slot >= 0)
      return {HEAP_DIR, SLOT_AW'(slot), PAGE_SHIFT'($urandom)};
    else if (pick < 75 && slot >= 0)
      // live slot but directory off by one bit
      return {HEAP_DIR ^ DIR_W'(1 << $urandom_range(DIR_W - 1, 0)), SLOT_AW'(slot),
              PAGE_SHIFT'($urandom)};
    else if (pick < 88)
      return {HEAP_DIR, SLOT_AW'($urandom), PAGE_SHIFT'($urandom)};
    else
      return $urandom;
  endfunction

  // random request words in bursts; alloc_pct sets the allocate share
  task automatic run_words(int count, int alloc_pct, bit with_gaps);
    int burst_left;
    burst_left = $urandom_range(12, 1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < alloc_pct)
        send_word(OP_ALLOC, $urandom);  // address is don't-care here
      else
        send_word(OP_FREE, free_address());
      burst_left--;
      if (with_gaps && burst_left == 0 && i != count - 1) begin
        drop_valid($urandom_range(10, 1));
        burst_left = $urandom_range(12, 1);
      end
    end
    drop_valid(1);
  endtask

  // pick a register value, mostly inside the documented range
  function automatic logic [CFG_W-1:0] random_reg();
    if ($urandom_range(3, 0) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(FRAME_COUNT, 0));
  endfunction

  initial begin : main
    int chunk;
    sb                 = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_SEARCH_START;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_opcode          = OP_ALLOC;
    in_virtual_address = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, window 1024..2047
    send_word(OP_ALLOC, 32'hFFFF_FFFF);  // slot 0, frame 1024
    send_word(OP_ALLOC, 32'h0000_0000);  // slot 1, frame 1025
    send_word(OP_FREE,  32'h0040_0ABC);  // offset bits ignored
    send_word(OP_FREE,  32'h0040_0000);  // slot no longer present
    send_word(OP_FREE,  32'hFFFF_FFFF);  // outside heap window
    send_word(OP_FREE,  32'h0000_0000);  // directory zero
    send_word(OP_FREE,  32'h007F_F000);  // top slot, never mapped
    send_word(OP_FREE,  32'h8040_1000);  // live slot, wrong directory
    send_word(OP_ALLOC, 32'h5555_5555);  // reuses slot 0 and frame 1024
    send_word(OP_FREE,  32'h0040_1FFF);  // release slot 1
    drop_valid(1);
    wait_idle();

    // empty search windows
    write_reg(CFG_SEARCH_START, 12'd2048);
    send_word(OP_ALLOC, 32'hAAAA_AAAA);
    drop_valid(1);
    wait_idle();
    write_reg(CFG_SEARCH_START, 12'd4095);
    write_reg(CFG_MEM_FRAMES, 12'd4095);
    send_word(OP_ALLOC, 32'h0);
    drop_valid(1);
    wait_idle();
    write_reg(CFG_SEARCH_START, 12'd0);
    write_reg(CFG_MEM_FRAMES, 12'd0);
    send_word(OP_ALLOC, 32'h0);
    send_word(OP_FREE,  32'h0040_0000);  // frees frame 1024 even with no window
    drop_valid(1);
    wait_idle();

    // oversized memory acts as the full frame count; frame 0 is handed out
    write_reg(CFG_MEM_FRAMES, 12'd4095);
    send_word(OP_ALLOC, 32'h0);
    send_word(OP_ALLOC, 32'h0);
    drop_valid(1);
    wait_idle();

    // top frame gives the widest physical address, then the window runs dry
    write_reg(CFG_SEARCH_START, 12'd2047);
    write_reg(CFG_MEM_FRAMES, 12'd2048);
    send_word(OP_ALLOC, 32'h0);
    send_word(OP_ALLOC, 32'h0);
    send_word(OP_FREE,  32'h0040_2000);
    send_word(OP_FREE,  32'h0040_0123);
    send_word(OP_FREE,  32'h0040_1000);
    send_word(OP_FREE,  32'h7FFF_FFFF);
    drop_valid(1);
    wait_idle();

    // random: reset window, with a long receiver hold-off early on
    write_reg(CFG_SEARCH_START, START_RST);
    hold_requests++;
    run_words(150, 55, 1'b1);
    wait_idle();

    // random: ten-frame window, frames run out often
    write_reg(CFG_SEARCH_START, 12'd1000);
    write_reg(CFG_MEM_FRAMES, 12'd1010);
    run_words(150, 60, 1'b1);
    wait_idle();

    // random: fill every slot with plenty of frames, then hit the full table
    write_reg(CFG_SEARCH_START, 12'd0);
    write_reg(CFG_MEM_FRAMES, 12'd2048);
    hold_requests++;
    chunk = 0;
    while (sb.slots_in_use() < SLOT_COUNT) begin
      run_words(40, 97, (chunk % 4) != 0);
      chunk++;
    end
    run_words(40, 85, 1'b1);
    wait_idle();

    // random: narrow window near the top, mostly frees draining the table
    write_reg(CFG_SEARCH_START, 12'd2000);
    write_reg(CFG_MEM_FRAMES, 12'd4095);
    run_words(200, 35, 1'b1);
    wait_idle();

    // random settings across the whole register range
    repeat (3) begin
      write_reg(CFG_SEARCH_START, random_reg());
      write_reg(CFG_MEM_FRAMES, random_reg());
      run_words(60, 50, 1'b1);
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    sb.check_drained();
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
